/* sv/pcs_pkg.sv */
// shared types and constants for the polygon half-plane clip stage
`default_nettype none
package pcs_pkg;

  localparam int CoordW = 16;
  localparam int CoefW  = 17;
  localparam int ConstW = 34;
  localparam int CountW = 9;
  localparam int DeltaW = 17;
  localparam int LineW  = 37;
  localparam int DenW   = 36;
  localparam int ProdW  = 54;
  localparam int QuotW  = 17;
  localparam int CfgIdxW = 2;

  localparam logic [CountW-1:0] CountCap = 9'd256;

  localparam logic [CfgIdxW-1:0] CFG_COEF_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEF_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_C = 2'd2;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_AX1, MUL_BY1, MUL_AX2, MUL_BY2, MUL_ADX, MUL_BDY, MUL_SDX, MUL_SDY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_C_P, ACC_P, ACC_S1, ACC_S2, ACC_DEN
  } acc_op_t;

  typedef enum logic {
    PROD_END, PROD_ISECT
  } prod_sel_t;

  typedef struct packed {
    logic      load;
    logic      edge_sel;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    logic      div_start;
    logic      isect_x_en;
    logic      isect_y_en;
    logic      produce;
    prod_sel_t prod_sel;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic have_first;
    logic fin;
    logic s1_neg;
    logic s2_neg;
    logic den_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* sv/pcs_div.sv */
// iterative restoring divider, one quotient bit per cycle, truncating signed result
`default_nettype none
module pcs_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [pcs_pkg::ProdW-1:0]      num,
  input  wire logic signed [pcs_pkg::DenW-1:0]       den,
  output logic                                       done,
  output logic signed [pcs_pkg::QuotW:0]             quot
);

  localparam int PW = pcs_pkg::ProdW;
  localparam int DW = pcs_pkg::DenW;
  localparam int QW = pcs_pkg::QuotW;
  localparam int RW = PW - QW;
  localparam int CW = $clog2(QW);

  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] qacc_r, qacc_nxt;
  logic [DW-1:0] dm_r;
  logic          neg_r;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] nm;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  assign nm    = num[PW-1] ? PW'(-num) : PW'(num);
  assign trial = {rem_r, qacc_r[QW-1]};
  assign diff  = trial - (RW+1)'(dm_r);

  always_comb begin
    rem_nxt  = rem_r;
    qacc_nxt = qacc_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = nm[PW-1:QW];
      qacc_nxt = nm[QW-1:0];
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[RW]) begin
        rem_nxt  = diff[RW-1:0];
        qacc_nxt = {qacc_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[RW-1:0];
        qacc_nxt = {qacc_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    qacc_r <= qacc_nxt;
    cnt_r  <= cnt_nxt;
    if (start) begin
      dm_r  <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_r <= num[PW-1] ^ den[DW-1];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, qacc_r}) : $signed({1'b0, qacc_r});

endmodule
`default_nettype wire

/* sv/pcs_dp.sv */
// datapath: coefficients, vertex store, shared multiplier, accumulator, divider, result registers
`default_nettype none
module pcs_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [pcs_pkg::CfgIdxW-1:0]            cfg_index,
  input  wire logic [pcs_pkg::ConstW-1:0]             cfg_data,
  input  wire logic signed [pcs_pkg::CoordW-1:0]      in_vertex_x,
  input  wire logic signed [pcs_pkg::CoordW-1:0]      in_vertex_y,
  input  wire logic                                   in_final_vertex,
  input  wire pcs_pkg::cmd_t                          cmd,
  output pcs_pkg::status_t                            status,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [pcs_pkg::CoordW-1:0]           out_x,
  output logic signed [pcs_pkg::CoordW-1:0]           out_y,
  output logic                                        out_vertex_valid,
  output logic                                        out_end_of_polygon,
  output logic [pcs_pkg::CountW-1:0]                  out_vertex_count
);

  localparam int XW = pcs_pkg::CoordW;
  localparam int AW = pcs_pkg::CoefW;
  localparam int DW = pcs_pkg::DeltaW;
  localparam int LW = pcs_pkg::LineW;
  localparam int NW = pcs_pkg::DenW;
  localparam int PW = pcs_pkg::ProdW;
  localparam int QW = pcs_pkg::QuotW;
  localparam int KW = pcs_pkg::CountW;

  logic signed [AW-1:0] coef_a_r, coef_b_r;
  logic signed [pcs_pkg::ConstW-1:0] coef_c_r;

  logic signed [XW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                 have_first_r, fin_r;
  logic [KW-1:0]        count_r;

  logic signed [PW-1:0] prod_r, acc_r;
  logic signed [LW-1:0] s1_r, s2_r;
  logic signed [NW-1:0] den_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [XW-1:0] ix_r, iy_r;

  logic                 pend_r;
  logic signed [XW-1:0] pend_x_r, pend_y_r;
  logic [KW-1:0]        pend_cnt_r;

  logic                 out_valid_r;
  logic signed [XW-1:0] out_x_r, out_y_r;
  logic                 out_vv_r, out_eop_r;
  logic [KW-1:0]        out_cnt_r;

  logic signed [XW-1:0] x1, y1, x2, y2;
  logic signed [LW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic signed [PW-1:0] sum_p;
  logic                 div_done;
  logic signed [QW:0]   quot;
  logic signed [QW+1:0] isect;
  logic signed [XW-1:0] isect_clamped;
  logic signed [XW-1:0] base;
  logic [KW-1:0]        count_inc;
  logic                 out_free;

  assign x1 = cmd.edge_sel ? cur_x_r   : prev_x_r;
  assign y1 = cmd.edge_sel ? cur_y_r   : prev_y_r;
  assign x2 = cmd.edge_sel ? first_x_r : cur_x_r;
  assign y2 = cmd.edge_sel ? first_y_r : cur_y_r;

  // operand selection for the one shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      pcs_pkg::MUL_AX1: begin op_a = LW'(coef_a_r); op_b = DW'(x1); end
      pcs_pkg::MUL_BY1: begin op_a = LW'(coef_b_r); op_b = DW'(y1); end
      pcs_pkg::MUL_AX2: begin op_a = LW'(coef_a_r); op_b = DW'(x2); end
      pcs_pkg::MUL_BY2: begin op_a = LW'(coef_b_r); op_b = DW'(y2); end
      pcs_pkg::MUL_ADX: begin op_a = LW'(coef_a_r); op_b = dx_r; end
      pcs_pkg::MUL_BDY: begin op_a = LW'(coef_b_r); op_b = dy_r; end
      pcs_pkg::MUL_SDX: begin op_a = s1_r; op_b = dx_r; end
      pcs_pkg::MUL_SDY: begin op_a = s1_r; op_b = dy_r; end
      default:          begin op_a = '0; op_b = '0; end
    endcase
  end

  assign sum_p = acc_r + prod_r;

  pcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  // intersection is start point minus the truncated quotient, clamped as a guard
  assign base  = cmd.isect_x_en ? x1 : y1;
  assign isect = (QW+2)'(base) - (QW+2)'(quot);
  always_comb begin
    if (isect > (QW+2)'(32767))
      isect_clamped = XW'(32767);
    else if (isect < -(QW+2)'(32768))
      isect_clamped = -XW'(32768);
    else
      isect_clamped = isect[XW-1:0];
  end

  assign count_inc = (count_r < pcs_pkg::CountCap) ? count_r + 1'b1 : count_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        pcs_pkg::CFG_COEF_A: coef_a_r <= cfg_data[AW-1:0];
        pcs_pkg::CFG_COEF_B: coef_b_r <= cfg_data[AW-1:0];
        pcs_pkg::CFG_COEF_C: coef_c_r <= cfg_data;
        default: ;
      endcase
    end

    if (cmd.mul_sel != pcs_pkg::MUL_NONE)
      prod_r <= PW'(op_a) * PW'(op_b);

    case (cmd.acc_op)
      pcs_pkg::ACC_C_P: acc_r <= PW'(coef_c_r) + prod_r;
      pcs_pkg::ACC_P:   acc_r <= prod_r;
      pcs_pkg::ACC_S1:  s1_r  <= sum_p[LW-1:0];
      pcs_pkg::ACC_S2: begin
        s2_r <= sum_p[LW-1:0];
        dx_r <= DW'(x2) - DW'(x1);
        dy_r <= DW'(y2) - DW'(y1);
      end
      pcs_pkg::ACC_DEN: den_r <= sum_p[NW-1:0];
      default: ;
    endcase

    if (cmd.isect_x_en) ix_r <= isect_clamped;
    if (cmd.isect_y_en) iy_r <= isect_clamped;

    if (cmd.load) begin
      cur_x_r <= in_vertex_x;
      cur_y_r <= in_vertex_y;
      fin_r   <= in_final_vertex;
      if (!have_first_r) begin
        first_x_r <= in_vertex_x;
        first_y_r <= in_vertex_y;
        prev_x_r  <= in_vertex_x;
        prev_y_r  <= in_vertex_y;
      end
    end

    // the newest result waits in pend so the last one of a polygon can carry the end flag
    if (cmd.produce) begin
      pend_x_r   <= (cmd.prod_sel == pcs_pkg::PROD_ISECT) ? ix_r : x2;
      pend_y_r   <= (cmd.prod_sel == pcs_pkg::PROD_ISECT) ? iy_r : y2;
      pend_cnt_r <= count_inc;
    end

    if ((cmd.produce && pend_r) || (cmd.flush && (pend_r || fin_r))) begin
      out_x_r   <= pend_r ? pend_x_r : '0;
      out_y_r   <= pend_r ? pend_y_r : '0;
      out_vv_r  <= pend_r;
      out_eop_r <= cmd.flush && fin_r;
      out_cnt_r <= pend_r ? pend_cnt_r : count_r;
    end

    if (cmd.flush) begin
      prev_x_r <= fin_r ? '0 : cur_x_r;
      prev_y_r <= fin_r ? '0 : cur_y_r;
      if (fin_r) begin
        first_x_r <= '0;
        first_y_r <= '0;
      end
    end

    if (!rst_n) begin
      coef_a_r     <= '0;
      coef_b_r     <= '0;
      coef_c_r     <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_first_r <= 1'b0;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load)
        have_first_r <= 1'b1;
      else if (cmd.flush && fin_r)
        have_first_r <= 1'b0;

      if (cmd.produce)
        count_r <= count_inc;
      else if (cmd.flush && fin_r)
        count_r <= '0;

      if (cmd.produce)
        pend_r <= 1'b1;
      else if (cmd.flush)
        pend_r <= 1'b0;

      if ((cmd.produce && pend_r) || (cmd.flush && (pend_r || fin_r)))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  assign status.have_first = have_first_r;
  assign status.fin        = fin_r;
  assign status.s1_neg     = s1_r[LW-1];
  assign status.s2_neg     = s2_r[LW-1];
  assign status.den_zero   = (den_r == '0);
  assign status.div_done   = div_done;
  assign status.out_free   = out_free;

  assign out_valid          = out_valid_r;
  assign out_x              = out_x_r;
  assign out_y              = out_y_r;
  assign out_vertex_valid   = out_vv_r;
  assign out_end_of_polygon = out_eop_r;
  assign out_vertex_count   = out_cnt_r;

endmodule
`default_nettype wire

/* sv/pcs_ctrl.sv */
// controller: sequences the line values, crossing, division and result transfers per edge
`default_nettype none
module pcs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_final_vertex,
  input  wire pcs_pkg::status_t status,
  output pcs_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7, ST_E8,
    ST_DIVX, ST_DIVY, ST_EMIT_I, ST_EMIT_E, ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   edge_sel_r, edge_sel_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = pcs_pkg::MUL_NONE;
    cmd.acc_op    = pcs_pkg::ACC_NONE;
    cmd.prod_sel  = pcs_pkg::PROD_END;
    cmd.edge_sel  = edge_sel_r;
    state_nxt     = state_r;
    edge_sel_nxt  = edge_sel_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (status.have_first) begin
            edge_sel_nxt = 1'b0;
            state_nxt    = ST_E0;
          end else if (in_final_vertex) begin
            edge_sel_nxt = 1'b1;
            state_nxt    = ST_E0;
          end
        end
      end
      ST_E0: begin
        cmd.mul_sel = pcs_pkg::MUL_AX1;
        state_nxt   = ST_E1;
      end
      ST_E1: begin
        cmd.mul_sel = pcs_pkg::MUL_BY1;
        cmd.acc_op  = pcs_pkg::ACC_C_P;
        state_nxt   = ST_E2;
      end
      ST_E2: begin
        cmd.mul_sel = pcs_pkg::MUL_AX2;
        cmd.acc_op  = pcs_pkg::ACC_S1;
        state_nxt   = ST_E3;
      end
      ST_E3: begin
        cmd.mul_sel = pcs_pkg::MUL_BY2;
        cmd.acc_op  = pcs_pkg::ACC_C_P;
        state_nxt   = ST_E4;
      end
      ST_E4: begin
        cmd.acc_op = pcs_pkg::ACC_S2;
        state_nxt  = ST_E5;
      end
      ST_E5: begin
        cmd.mul_sel = pcs_pkg::MUL_ADX;
        if (!status.s1_neg && !status.s2_neg)
          state_nxt = ST_FLUSH;
        else if (status.s1_neg && status.s2_neg)
          state_nxt = ST_EMIT_E;
        else
          state_nxt = ST_E6;
      end
      ST_E6: begin
        cmd.mul_sel = pcs_pkg::MUL_BDY;
        cmd.acc_op  = pcs_pkg::ACC_P;
        state_nxt   = ST_E7;
      end
      ST_E7: begin
        cmd.mul_sel = pcs_pkg::MUL_SDX;
        cmd.acc_op  = pcs_pkg::ACC_DEN;
        state_nxt   = ST_E8;
      end
      ST_E8: begin
        cmd.mul_sel = pcs_pkg::MUL_SDY;
        if (status.den_zero) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (status.div_done) begin
          cmd.isect_x_en = 1'b1;
          cmd.div_start  = 1'b1;
          state_nxt      = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (status.div_done) begin
          cmd.isect_y_en = 1'b1;
          state_nxt      = ST_EMIT_I;
        end
      end
      ST_EMIT_I: begin
        if (status.out_free) begin
          cmd.produce  = 1'b1;
          cmd.prod_sel = pcs_pkg::PROD_ISECT;
          state_nxt    = status.s1_neg ? ST_FLUSH : ST_EMIT_E;
        end
      end
      ST_EMIT_E: begin
        if (status.out_free) begin
          cmd.produce  = 1'b1;
          cmd.prod_sel = pcs_pkg::PROD_END;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // the closing edge back to the first vertex follows the regular one
        if (!edge_sel_r && status.fin) begin
          edge_sel_nxt = 1'b1;
          state_nxt    = ST_E0;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      edge_sel_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_sel_r <= edge_sel_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/polygon_halfplane_clip_stage.sv */
// top level of the streaming polygon half-plane clip stage
//
// One vertex is taken at a time and clipped against coef_a*x + coef_b*y + coef_c < 0.
// Each edge first finds both line values. A crossing edge then forms the
// denominator and runs two divisions on the shared restoring divider. Each result
// waits for a free output register. A vertex after the first closes one edge, and the
// final vertex of a longer polygon closes two. Results of a final vertex carry
// end_of_polygon on the last one. A polygon with nothing inside gives one marker
// result.
`default_nettype none
module polygon_halfplane_clip_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pcs_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [pcs_pkg::ConstW-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [pcs_pkg::CoordW-1:0]   in_vertex_x,
  input  wire logic signed [pcs_pkg::CoordW-1:0]   in_vertex_y,
  input  wire logic                                in_final_vertex,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pcs_pkg::CoordW-1:0]        out_x,
  output logic signed [pcs_pkg::CoordW-1:0]        out_y,
  output logic                                     out_vertex_valid,
  output logic                                     out_end_of_polygon,
  output logic [pcs_pkg::CountW-1:0]               out_vertex_count
);

  pcs_pkg::cmd_t    cmd;
  pcs_pkg::status_t status;

  pcs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_final_vertex (in_final_vertex),
    .status          (status),
    .cmd             (cmd)
  );

  pcs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_vertex_x        (in_vertex_x),
    .in_vertex_y        (in_vertex_y),
    .in_final_vertex    (in_final_vertex),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_vertex_valid   (out_vertex_valid),
    .out_end_of_polygon (out_end_of_polygon),
    .out_vertex_count   (out_vertex_count)
  );

endmodule
`default_nettype wire
